// ===== sv/fpcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpcp_pkg
// Shared types, register indexes and the CRC-16/CCITT-FALSE byte update for
// the framed packet parser.
// ----------------------------------------------------------------------------
package fpcp_pkg;

	// CRC-16/CCITT-FALSE constants
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
	localparam logic [15:0] MAX_LEN_RST     = 16'd1024;

	// Live configuration seen by the parser
	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] max_payload_len;
	} fpcp_cfg_t;

	// One result word
	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic        frame_ok;
		logic        crc_error;
		logic        length_error;
		logic [7:0]  frame_command;
		logic [15:0] frame_length;
	} fpcp_result_t;

	// One byte through the MSB-first CRC shift register
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== sv/fpcp_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpcp_parser
// Frame state machine: sync hunt, header capture, payload indexing and the
// running CRC. One byte is consumed on each step; the result is combinational.
// ----------------------------------------------------------------------------
module fpcp_parser
	import fpcp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   rx_byte,
	input  wire fpcp_cfg_t    cfg,
	output fpcp_result_t      res
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SYNC1 = 3'd1;
	localparam logic [2:0] PH_SYNC2 = 3'd2;
	localparam logic [2:0] PH_CMD   = 3'd3;
	localparam logic [2:0] PH_LENH  = 3'd4;
	localparam logic [2:0] PH_DATA  = 3'd5;
	localparam logic [2:0] PH_CRC1  = 3'd6;
	localparam logic [2:0] PH_CRC2  = 3'd7;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  command_q, command_d;
	logic [15:0] length_q, length_d;
	logic [15:0] count_q, count_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [15:0] crc_upd;
	logic [15:0] count_inc;
	logic [15:0] len_full;

	// CRC over the current byte, seeded fresh on the command byte
	assign crc_upd   = crc_byte((phase_q == PH_SYNC2) ? CRC_INIT : crc_q, rx_byte);
	assign count_inc = count_q + 16'd1;
	assign len_full  = {length_q[15:8], rx_byte};

	// Next state and result for this byte
	always_comb begin
		phase_d   = phase_q;
		command_d = command_q;
		length_d  = length_q;
		count_d   = count_q;
		crc_d     = crc_q;
		crc_lo_d  = crc_lo_q;
		res       = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (rx_byte == cfg.sync_first) begin
					phase_d = PH_SYNC1;
				end
			end
			PH_SYNC1: begin
				// second sync wins when both values are equal
				if (rx_byte == cfg.sync_second) begin
					phase_d = PH_SYNC2;
				end else if (rx_byte != cfg.sync_first) begin
					phase_d = PH_IDLE;
				end
			end
			PH_SYNC2: begin
				command_d = rx_byte;
				crc_d     = crc_upd;
				phase_d   = PH_CMD;
			end
			PH_CMD: begin
				length_d = {rx_byte, 8'h00};
				crc_d    = crc_upd;
				phase_d  = PH_LENH;
			end
			PH_LENH: begin
				length_d = len_full;
				crc_d    = crc_upd;
				count_d  = '0;
				if (len_full > cfg.max_payload_len) begin
					res.length_error = 1'b1;
					phase_d          = PH_IDLE;
				end else if (len_full == 16'd0) begin
					phase_d = PH_CRC1;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = count_q;
				count_d           = count_inc;
				crc_d             = crc_upd;
				if (count_inc >= length_q) begin
					phase_d = PH_CRC1;
				end
			end
			PH_CRC1: begin
				crc_lo_d = rx_byte;
				phase_d  = PH_CRC2;
			end
			PH_CRC2: begin
				if ({rx_byte, crc_lo_q} == crc_q) begin
					res.frame_ok = 1'b1;
				end else begin
					res.crc_error = 1'b1;
				end
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		res.frame_command = command_d;
		res.frame_length  = length_d;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			command_q <= '0;
			length_q  <= '0;
			count_q   <= '0;
			crc_q     <= '0;
			crc_lo_q  <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			command_q <= command_d;
			length_q  <= length_d;
			count_q   <= count_d;
			crc_q     <= crc_d;
			crc_lo_q  <= crc_lo_d;
		end
	end

`ifndef SYNTHESIS
	// at most one flag per word
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> $onehot0({res.payload_valid, res.frame_ok, res.crc_error, res.length_error}))
		else $error("fpcp_parser: more than one result flag set");

	// payload index stays inside the declared length
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.payload_valid) |-> (res.payload_index < res.frame_length))
		else $error("fpcp_parser: payload index beyond frame length");

	// a length error sends the parser back to the hunt
	a_len_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.length_error) |=> (phase_q == PH_IDLE))
		else $error("fpcp_parser: no return to hunt after length error");

	// frame end flags only come from the last CRC byte
	a_end_from_crc2: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (res.frame_ok || res.crc_error)) |-> (phase_q == PH_CRC2))
		else $error("fpcp_parser: frame end flagged outside CRC phase");
`endif

endmodule
`default_nettype wire

// ===== sv/framed_packet_crc_parser.sv =====
`default_nettype none
// Order: input register, parser, result register; the result word shows on out_valid.
// Throughput: one byte per cycle while no result waits on out_stall; the input and result
//   registers decouple the channels, so one byte is still taken while a result waits.
// Reset: arst_n clears both registers' valids, the parser to hunting and the
//   configuration to sync 0xAA/0x55 and a maximum length of 1024.
// ----------------------------------------------------------------------------
// framed_packet_crc_parser
// Byte-stream frame parser with CRC-16/CCITT-FALSE check: input register,
// single-pass parser and result register, plus the configuration registers.
// ----------------------------------------------------------------------------
module framed_packet_crc_parser
	import fpcp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// byte input
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           rx_byte,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      payload_valid,
	output logic [7:0]                payload_byte,
	output logic [15:0]               payload_index,
	output logic                      frame_ok,
	output logic                      crc_error,
	output logic                      length_error,
	output logic [7:0]                frame_command,
	output logic [15:0]               frame_length,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	fpcp_cfg_t    cfg_q;
	logic         s1_valid_q;
	logic [7:0]   rx_byte_s1;
	logic         out_valid_q;
	fpcp_result_t res_q;
	fpcp_result_t res;
	logic         out_free;
	logic         step;
	logic         in_take;

	// handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign step      = s1_valid_q && out_free;
	assign in_stall  = s1_valid_q && !out_free;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first      <= SYNC_FIRST_RST;
			cfg_q.sync_second     <= SYNC_SECOND_RST;
			cfg_q.max_payload_len <= MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:  cfg_q.sync_first      <= cfg_data[7:0];
				CFG_SYNC_SECOND: cfg_q.sync_second     <= cfg_data[7:0];
				CFG_MAX_LEN:     cfg_q.max_payload_len <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_take || (s1_valid_q && !out_free);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	fpcp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_valid = res_q.payload_valid;
	assign payload_byte  = res_q.payload_byte;
	assign payload_index = res_q.payload_index;
	assign frame_ok      = res_q.frame_ok;
	assign crc_error     = res_q.crc_error;
	assign length_error  = res_q.length_error;
	assign frame_command = res_q.frame_command;
	assign frame_length  = res_q.frame_length;

`ifndef SYNTHESIS
	// a word in the input register moves on whenever the result side is free
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_free) |=> out_valid_q)
		else $error("framed_packet_crc_parser: input word not forwarded");

	// input is only held back when both registers are full
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("framed_packet_crc_parser: stall with free space");

	// a held result word is not overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(res_q)))
		else $error("framed_packet_crc_parser: stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_framed_packet_crc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_packet_crc_parser
// Self-checking bench for the framed packet parser. A byte-level predictor
// tracks sync hunting, header, payload and CRC checking. Every result word is
// compared field by field against a queue of predicted words. Directed frames
// cover the corner cases first. Randomized traffic follows under several
// register settings, and frames under the widest length limit end the run.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_framed_packet_crc_parser;
	import fpcp_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int IDLE_PCT     = 22;

	// index with no register behind it; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// parser phases as the predictor sees them
	typedef enum logic [2:0] {
		P_HUNT,
		P_WAIT_SYNC2,
		P_WAIT_CMD,
		P_WAIT_LEN_HI,
		P_WAIT_LEN_LO,
		P_PAYLOAD,
		P_WAIT_CRC_LO,
		P_WAIT_CRC_HI
	} parse_phase_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 payload_valid;
	logic [7:0]           payload_byte;
	logic [15:0]          payload_index;
	logic                 frame_ok;
	logic                 crc_error;
	logic                 length_error;
	logic [7:0]           frame_command;
	logic [15:0]          frame_length;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
	logic [15:0]          cfg_data = 16'h0000;

	// predictor state and register shadow
	fpcp_cfg_t    shadow_cfg;
	parse_phase_e prs_phase;
	logic [7:0]   prs_cmd;
	logic [15:0]  prs_len;
	logic [15:0]  prs_count;
	logic [15:0]  prs_crc;
	logic [7:0]   prs_crc_lo;

	fpcp_result_t expected_words[$];

	bit steady_flow = 1'b0;
	int fail_count = 0;
	int bytes_sent = 0;
	int words_checked = 0;
	int payload_words = 0;
	int good_frames = 0;
	int bad_crc_frames = 0;
	int len_rejects = 0;
	int reg_writes = 0;
	int cycle_count = 0;

	framed_packet_crc_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_ok      (frame_ok),
		.crc_error     (crc_error),
		.length_error  (length_error),
		.frame_command (frame_command),
		.frame_length  (frame_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// CRC-16/CCITT-FALSE, one input bit at a time, MSB first
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// advance the parser model by one byte, return the word it should emit
	function automatic fpcp_result_t predict_word(input logic [7:0] b);
		fpcp_result_t r;
		r = '0;
		case (prs_phase)
			P_HUNT: begin
				if (b == shadow_cfg.sync_first) begin
					prs_phase = P_WAIT_SYNC2;
				end
			end
			P_WAIT_SYNC2: begin
				// second sync wins over a repeated first sync
				if (b == shadow_cfg.sync_second) begin
					prs_phase = P_WAIT_CMD;
				end else if (b != shadow_cfg.sync_first) begin
					prs_phase = P_HUNT;
				end
			end
			P_WAIT_CMD: begin
				prs_cmd = b;
				prs_crc = crc_step(CRC_INIT, b);
				prs_phase = P_WAIT_LEN_HI;
			end
			P_WAIT_LEN_HI: begin
				prs_len = {b, 8'h00};
				prs_crc = crc_step(prs_crc, b);
				prs_phase = P_WAIT_LEN_LO;
			end
			P_WAIT_LEN_LO: begin
				prs_len[7:0] = b;
				prs_crc = crc_step(prs_crc, b);
				prs_count = '0;
				if (prs_len > shadow_cfg.max_payload_len) begin
					r.length_error = 1'b1;
					prs_phase = P_HUNT;
				end else if (prs_len == 16'h0000) begin
					prs_phase = P_WAIT_CRC_LO;
				end else begin
					prs_phase = P_PAYLOAD;
				end
			end
			P_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				r.payload_index = prs_count;
				prs_count = prs_count + 16'd1;
				prs_crc = crc_step(prs_crc, b);
				if (prs_count >= prs_len) begin
					prs_phase = P_WAIT_CRC_LO;
				end
			end
			P_WAIT_CRC_LO: begin
				prs_crc_lo = b;
				prs_phase = P_WAIT_CRC_HI;
			end
			default: begin
				// CRC arrives little-endian
				if ({b, prs_crc_lo} == prs_crc) begin
					r.frame_ok = 1'b1;
				end else begin
					r.crc_error = 1'b1;
				end
				prs_phase = P_HUNT;
			end
		endcase
		r.frame_command = prs_cmd;
		r.frame_length = prs_len;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// output side: random stall, dropped during steady stretches
	always @(posedge clk) begin
		out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
	end

	// result checker: each accepted word against the oldest prediction
	always @(posedge clk) begin : result_check
		fpcp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("result word with no byte pending");
				fail_count++;
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				check_field("payload_valid", 16'(want.payload_valid), 16'(payload_valid));
				check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
				check_field("payload_index", want.payload_index, payload_index);
				check_field("frame_ok", 16'(want.frame_ok), 16'(frame_ok));
				check_field("crc_error", 16'(want.crc_error), 16'(crc_error));
				check_field("length_error", 16'(want.length_error), 16'(length_error));
				check_field("frame_command", 16'(want.frame_command), 16'(frame_command));
				check_field("frame_length", want.frame_length, frame_length);
				payload_words += int'(want.payload_valid);
				good_frames += int'(want.frame_ok);
				bad_crc_frames += int'(want.crc_error);
				len_rejects += int'(want.length_error);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// one byte word through the input handshake, predicted on acceptance
	task automatic send_byte(input logic [7:0] b);
		if (!steady_flow && ($urandom_range(99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!(in_valid && !in_stall));
		expected_words.push_back(predict_word(b));
		bytes_sent++;
	endtask

	// stop sending and let every word in flight come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SYNC_FIRST:  shadow_cfg.sync_first = data[7:0];
			CFG_SYNC_SECOND: shadow_cfg.sync_second = data[7:0];
			CFG_MAX_LEN:     shadow_cfg.max_payload_len = data;
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// sync, command, length, payload, CRC; header only when the length is over the limit
	task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input bit bad_crc);
		logic [15:0] crc;
		logic [7:0]  pb;
		logic [7:0]  flip;
		send_byte(shadow_cfg.sync_first);
		send_byte(shadow_cfg.sync_second);
		crc = crc_step(CRC_INIT, cmd);
		send_byte(cmd);
		crc = crc_step(crc, len[15:8]);
		send_byte(len[15:8]);
		crc = crc_step(crc, len[7:0]);
		send_byte(len[7:0]);
		if (len > shadow_cfg.max_payload_len) begin
			return;
		end
		for (int i = 0; i < int'(len); i++) begin
			pb = 8'($urandom);
			crc = crc_step(crc, pb);
			send_byte(pb);
		end
		if (bad_crc) begin
			flip = 8'($urandom_range(255, 1));
			if ($urandom_range(1) == 0) begin
				crc[7:0] = crc[7:0] ^ flip;
			end else begin
				crc[15:8] = crc[15:8] ^ flip;
			end
		end
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
	endtask

	// reset values: smallest frame with extreme byte values
	task automatic test_reset_frame();
		send_frame(8'hFF, 16'h0000, 1'b0);
		send_frame(8'h00, 16'h0000, 1'b1);
	endtask

	// lost sync drops back, repeated first sync keeps the hunt armed
	task automatic test_sync_hunt();
		send_byte(SYNC_FIRST_RST);
		send_byte(8'h13);
		send_byte(SYNC_FIRST_RST);
		send_byte(SYNC_FIRST_RST);
		send_frame(8'h5A, 16'h0001, 1'b1);
	endtask

	// declared length above the limit, limit changed while a header is open
	task automatic test_length_limit();
		logic [15:0] spare_data;
		send_frame(8'hC3, 16'hFFFF, 1'b0);
		send_byte(shadow_cfg.sync_first);
		send_byte(shadow_cfg.sync_second);
		send_byte(8'h81);
		send_byte(8'h00);
		write_reg(CFG_MAX_LEN, 16'h0000);
		spare_data = 16'($urandom);
		write_reg(CFG_SPARE, spare_data);
		send_byte(8'h01);
	endtask

	// identical sync values: the second match wins
	task automatic test_equal_sync();
		write_reg(CFG_SYNC_FIRST, 16'hA57E);
		write_reg(CFG_SYNC_SECOND, 16'h5A7E);
		send_byte(8'h7E);
		send_frame(8'h42, 16'h0000, 1'b0);
		wait_idle();
	endtask

	// random frames, length rejects and noise under one register setting
	task automatic run_traffic_phase(input logic [7:0] s1, input logic [7:0] s2,
			input logic [15:0] max_len, input bit no_gaps, input int n_bytes);
		int         start;
		int         pick;
		int         len;
		int         cap;
		logic [7:0] b;
		write_reg(CFG_SYNC_FIRST, {8'($urandom), s1});
		write_reg(CFG_SYNC_SECOND, {8'($urandom), s2});
		write_reg(CFG_MAX_LEN, max_len);
		if ($urandom_range(3) == 0) begin
			write_reg(CFG_SPARE, 16'($urandom));
		end
		steady_flow = no_gaps;
		cap = (max_len < 16'd12) ? int'(max_len) : 12;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 62) begin
				len = $urandom_range(cap, 0);
				send_frame(8'($urandom), 16'(len), $urandom_range(99) < 15);
			end else if (pick < 72) begin
				if (max_len != 16'hFFFF) begin
					len = $urandom_range(65535, int'(max_len) + 1);
				end else begin
					len = $urandom_range(cap, 0);
				end
				send_frame(8'($urandom), 16'(len), 1'b0);
			end else if (pick < 78) begin
				// exactly at the limit, or a longer payload
				len = (max_len <= 16'd40) ? int'(max_len) : $urandom_range(40, 13);
				send_frame(8'($urandom), 16'(len), $urandom_range(1) == 1);
			end else begin
				repeat ($urandom_range(6, 1)) begin
					if ($urandom_range(99) < 30) begin
						b = ($urandom_range(1) == 0) ? s1 : s2;
					end else begin
						b = 8'($urandom);
					end
					send_byte(b);
				end
			end
		end
		wait_idle();
		steady_flow = 1'b0;
	endtask

	task automatic test_random_traffic();
		logic [7:0] s;
		run_traffic_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LEN_RST, 1'b0, 90);
		run_traffic_phase(8'h00, 8'hFF, 16'hFFFF, 1'b0, 90);
		run_traffic_phase(8'hFF, 8'h00, 16'h0000, 1'b0, 90);
		s = 8'($urandom);
		run_traffic_phase(s, s, 16'd16, 1'b0, 90);
		run_traffic_phase(8'($urandom), 8'($urandom), 16'($urandom), 1'b1, 100);
		run_traffic_phase(8'($urandom), 8'($urandom), 16'd5, 1'b0, 90);
		run_traffic_phase(8'($urandom), 8'($urandom), 16'd1, 1'b0, 90);
		run_traffic_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, 16'd40, 1'b0, 90);
	endtask

	// full 16-bit limit: no declared length can be rejected
	task automatic test_longest_frame();
		write_reg(CFG_MAX_LEN, 16'hFFFF);
		send_frame(8'($urandom), 16'd48, 1'b0);
		send_frame(8'($urandom), 16'h0003, 1'b1);
	endtask

	initial begin
		shadow_cfg.sync_first = SYNC_FIRST_RST;
		shadow_cfg.sync_second = SYNC_SECOND_RST;
		shadow_cfg.max_payload_len = MAX_LEN_RST;
		prs_phase = P_HUNT;
		prs_cmd = '0;
		prs_len = '0;
		prs_count = '0;
		prs_crc = '0;
		prs_crc_lo = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_frame();
		test_sync_hunt();
		test_length_limit();
		test_equal_sync();
		test_random_traffic();
		test_longest_frame();

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes with %0d register writes; %0d result words checked.",
			bytes_sent, reg_writes, words_checked);
		$display("Seen: %0d payload words, %0d good frames, %0d CRC errors, %0d length rejects.",
			payload_words, good_frames, bad_crc_frames, len_rejects);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
